// File: rtl/ps2m_pkg.sv
// Shared types, constants and arithmetic helpers for the PS/2 mouse packet decoder.
package ps2m_pkg;

  // Framing phase of the byte stream
  typedef enum logic [1:0] {
    PH_ACK    = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2,
    PH_THIRD  = 2'd3
  } phase_e;

  // Register indexes on the configuration port
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  localparam logic [7:0]  ACK_BYTE      = 8'hFA;
  localparam logic [7:0]  SYNC_MASK     = 8'hC8;
  localparam logic [7:0]  SYNC_VALUE    = 8'h08;
  localparam int unsigned BTN_BITS      = 3;
  localparam int unsigned X_SIGN_BIT    = 4;
  localparam int unsigned Y_SIGN_BIT    = 5;
  localparam int unsigned TASKBAR_ROWS  = 28;
  localparam logic [11:0] RESET_WIDTH   = 12'd320;
  localparam logic [11:0] RESET_HEIGHT  = 12'd200;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

  // One framed packet as it travels from front to back
  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] third;
  } pkt_t;

  // Configuration writes seen by the cursor logic
  typedef struct packed {
    logic        wr_width;
    logic        wr_height;
    logic [11:0] width;
    logic [11:0] height;
  } cfg_t;

  // Centre position: (span - margin) / 2, floored at zero
  function automatic logic [11:0] centre_of(logic [11:0] span, logic [7:0] margin);
    logic signed [13:0] v;
    v = $signed({2'b00, span}) - $signed({6'b000000, margin});
    if (v < 0) begin
      v = '0;
    end
    return v[12:1];
  endfunction

  // Add a delta and clamp to 0 .. span - size (upper bound floored at zero)
  function automatic logic [11:0] clamp_axis(logic [11:0] pos, logic signed [9:0] delta,
                                             logic [11:0] span, logic [6:0] size);
    logic signed [13:0] sum;
    logic signed [13:0] upper;
    sum   = $signed({2'b00, pos}) + $signed({{4{delta[9]}}, delta});
    upper = $signed({2'b00, span}) - $signed({7'b0000000, size});
    if (upper < 0) begin
      upper = '0;
    end
    if (sum < 0) begin
      sum = '0;
    end else if (sum > upper) begin
      sum = upper;
    end
    return sum[11:0];
  endfunction

endpackage

// File: rtl/ps2m_front.sv
// Byte framer: waits for the acknowledge, resynchronises and assembles packets.
module ps2m_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      rx_byte_i,
  output logic            pkt_push_o,
  output ps2m_pkg::pkt_t  pkt_o
);

  ps2m_pkg::phase_e phase_q, phase_d;
  logic [7:0] first_q;
  logic [7:0] second_q;
  logic       cap_first;
  logic       cap_second;
  logic       sync_ok;

  assign sync_ok = (rx_byte_i & ps2m_pkg::SYNC_MASK) == ps2m_pkg::SYNC_VALUE;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      case (phase_q)
        ps2m_pkg::PH_ACK: begin
          if (rx_byte_i == ps2m_pkg::ACK_BYTE) phase_d = ps2m_pkg::PH_FIRST;
        end
        ps2m_pkg::PH_FIRST: begin
          if (sync_ok) phase_d = ps2m_pkg::PH_SECOND;
        end
        ps2m_pkg::PH_SECOND: phase_d = ps2m_pkg::PH_THIRD;
        ps2m_pkg::PH_THIRD:  phase_d = ps2m_pkg::PH_FIRST;
        default:             phase_d = ps2m_pkg::PH_ACK;
      endcase
    end
  end

  // Capture enables and packet push
  always_comb begin
    cap_first  = 1'b0;
    cap_second = 1'b0;
    pkt_push_o = 1'b0;
    case (phase_q)
      ps2m_pkg::PH_FIRST:  cap_first  = accept_i & sync_ok;
      ps2m_pkg::PH_SECOND: cap_second = accept_i;
      ps2m_pkg::PH_THIRD:  pkt_push_o = accept_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ps2m_pkg::PH_ACK;
      first_q  <= '0;
      second_q <= '0;
    end else begin
      phase_q <= phase_d;
      if (cap_first)  first_q  <= rx_byte_i;
      if (cap_second) second_q <= rx_byte_i;
    end
  end

  // Third byte goes straight into the queue
  assign pkt_o = '{first: first_q, second: second_q, third: rx_byte_i};

endmodule

// File: rtl/ps2m_queue.sv
// Short packet queue between framer and cursor logic.
module ps2m_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ps2m_pkg::pkt_t  pkt_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output ps2m_pkg::pkt_t  pkt_o
);

  ps2m_pkg::pkt_t entry_q [ps2m_pkg::QUEUE_DEPTH];
  logic [ps2m_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [ps2m_pkg::QUEUE_CNT_W-1:0] count_q;

  assign full_o  = count_q == ps2m_pkg::QUEUE_CNT_W'(ps2m_pkg::QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign pkt_o   = entry_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= pkt_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/ps2m_back.sv
// Packet executor: deltas, clamped cursor update and the result register.
module ps2m_back #(
  parameter int CursorSize = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ps2m_pkg::cfg_t      cfg_i,
  input  logic                pkt_valid_i,
  input  ps2m_pkg::pkt_t      pkt_i,
  output logic                pkt_pop_o,
  output logic                out_valid_o,
  input  logic                out_take_i,
  output logic [2:0]          buttons_o,
  output logic signed [8:0]   delta_x_o,
  output logic signed [9:0]   delta_y_o,
  output logic [11:0]         cursor_x_o,
  output logic [11:0]         cursor_y_o
);

  localparam logic [6:0] SizeW    = 7'(CursorSize);
  localparam logic [7:0] MarginX  = 8'(CursorSize);
  localparam logic [7:0] MarginY  = 8'(ps2m_pkg::TASKBAR_ROWS + CursorSize);

  logic [11:0]        ptr_x_q, ptr_y_q;
  logic [11:0]        ptr_x_d, ptr_y_d;
  logic               out_valid_q;
  logic signed [8:0]  dx;
  logic signed [9:0]  dy;
  logic               ready;

  // Sign-extended deltas, Y negated so that down is positive
  assign dx = {pkt_i.first[ps2m_pkg::X_SIGN_BIT], pkt_i.second};
  assign dy = 10'sd0 - $signed({{2{pkt_i.first[ps2m_pkg::Y_SIGN_BIT]}}, pkt_i.third});

  assign ready     = !out_valid_q || out_take_i;
  assign pkt_pop_o = pkt_valid_i && ready;

  assign ptr_x_d = ps2m_pkg::clamp_axis(ptr_x_q, {dx[8], dx}, cfg_i.width, SizeW);
  assign ptr_y_d = ps2m_pkg::clamp_axis(ptr_y_q, dy, cfg_i.height, SizeW);

  // Cursor position and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_x_q     <= ps2m_pkg::centre_of(ps2m_pkg::RESET_WIDTH, MarginX);
      ptr_y_q     <= ps2m_pkg::centre_of(ps2m_pkg::RESET_HEIGHT, MarginY);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.wr_width) begin
        ptr_x_q <= ps2m_pkg::centre_of(cfg_i.width, MarginX);
      end else if (pkt_pop_o) begin
        ptr_x_q <= ptr_x_d;
      end
      if (cfg_i.wr_height) begin
        ptr_y_q <= ps2m_pkg::centre_of(cfg_i.height, MarginY);
      end else if (pkt_pop_o) begin
        ptr_y_q <= ptr_y_d;
      end
      if (pkt_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_take_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pkt_pop_o) begin
      buttons_o  <= pkt_i.first[ps2m_pkg::BTN_BITS-1:0];
      delta_x_o  <= dx;
      delta_y_o  <= dy;
      cursor_x_o <= ptr_x_d;
      cursor_y_o <= ptr_y_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/ps2_mouse_packet_cursor_core.sv
// Top level of the PS/2 mouse packet decoder with clamped cursor.
// Takes one mouse byte per cycle whenever full is low: the framer handles each
// byte as it arrives and only stalls when the two-word packet queue is
// full, which happens only while results are not being popped. A packet is
// registered first in the queue, then, once the result register is free, the
// cursor adder and clamp feed the result register, and one packet
// completes every three bytes. Bytes are ignored until the 0xFA acknowledge.
// Writing screen_width or screen_height recentres that axis of the cursor.
module ps2_mouse_packet_cursor_core #(
  parameter int CURSOR_SIZE = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // byte input
  input  logic                push,
  output logic                full,
  input  logic [7:0]          rx_byte_i,
  // result output
  output logic                empty,
  input  logic                pop,
  output logic [2:0]          buttons_o,
  output logic signed [8:0]   delta_x_o,
  output logic signed [9:0]   delta_y_o,
  output logic [11:0]         cursor_x_o,
  output logic [11:0]         cursor_y_o
);

  logic [11:0]        width_q, height_q;
  logic               cfg_wr;
  ps2m_pkg::reg_idx_e cfg_idx;
  ps2m_pkg::cfg_t     cfg;
  logic               accept;
  logic               pkt_push;
  ps2m_pkg::pkt_t     pkt_in, pkt_out;
  logic               q_full, q_valid, q_pop;
  logic               out_valid;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = ps2m_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ps2m_pkg::RESET_WIDTH;
      height_q <= ps2m_pkg::RESET_HEIGHT;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ps2m_pkg::REG_WIDTH:  width_q  <= pwdata[11:0];
        ps2m_pkg::REG_HEIGHT: height_q <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      ps2m_pkg::REG_WIDTH:  prdata = {20'd0, width_q};
      ps2m_pkg::REG_HEIGHT: prdata = {20'd0, height_q};
      default:              prdata = '0;
    endcase
  end

  // New register values reach the cursor logic together with the write strobe
  assign cfg.wr_width  = cfg_wr && (cfg_idx == ps2m_pkg::REG_WIDTH);
  assign cfg.wr_height = cfg_wr && (cfg_idx == ps2m_pkg::REG_HEIGHT);
  assign cfg.width     = cfg.wr_width  ? pwdata[11:0] : width_q;
  assign cfg.height    = cfg.wr_height ? pwdata[11:0] : height_q;

  // Input handshake
  assign full   = q_full;
  assign accept = push && !q_full;

  ps2m_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .pkt_push_o (pkt_push),
    .pkt_o      (pkt_in)
  );

  ps2m_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pkt_push),
    .pkt_i   (pkt_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .pkt_o   (pkt_out)
  );

  ps2m_back #(
    .CursorSize (CURSOR_SIZE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pkt_valid_i (q_valid),
    .pkt_i       (pkt_out),
    .pkt_pop_o   (q_pop),
    .out_valid_o (out_valid),
    .out_take_i  (pop),
    .buttons_o   (buttons_o),
    .delta_x_o   (delta_x_o),
    .delta_y_o   (delta_y_o),
    .cursor_x_o  (cursor_x_o),
    .cursor_y_o  (cursor_y_o)
  );

  assign empty = !out_valid;

  // Negated Y delta never reaches -256
  a_dy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> delta_y_o != -10'sd256)
    else $error("delta_y out of range");

  // A waiting packet is kept while the result word is stalled
  a_queue_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && !empty && !pop) |=> q_valid)
    else $error("queued packet lost while result stalled");

  // Taking the last result with nothing queued leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !q_valid) |=> empty)
    else $error("result word repeated");

endmodule

// File: sim/ps2_mouse_packet_cursor_core_tb.sv
// Self-checking testbench for the PS/2 mouse packet decoder with clamped cursor.
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor_core_tb;

  localparam int CURSOR      = 16;
  localparam int ITEMS       = 1650;
  localparam int PHASES      = 6;
  localparam int SETTLE      = 8;
  localparam int STALL_LIMIT = 4000;

  // One cursor report as the block should present it
  typedef struct {
    logic [2:0]        buttons;
    logic signed [8:0] dx;
    logic signed [9:0] dy;
    logic [11:0]       cx;
    logic [11:0]       cy;
  } cursor_report_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               push;
  logic               full;
  logic [7:0]         rx_byte_i;
  logic               empty;
  logic               pop = 1'b0;
  logic [2:0]         buttons_o;
  logic signed [8:0]  delta_x_o;
  logic signed [9:0]  delta_y_o;
  logic [11:0]        cursor_x_o;
  logic [11:0]        cursor_y_o;

  // Decoder state as tracked on the testbench side
  ps2m_pkg::phase_e frame_ph;
  logic [7:0]       head_byte;
  logic [7:0]       x_byte;
  int               ptr_x;
  int               ptr_y;
  int               scr_w;
  int               scr_h;

  // Report words still owed by the block, oldest first
  cursor_report_t pending_reports[$];

  int          errors;
  int          burst_left;
  int          quiet_cycles;
  int          pop_tick;
  int          pop_mode;
  logic [15:0] pop_mask;

  ps2_mouse_packet_cursor_core #(
    .CURSOR_SIZE(CURSOR)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .push       (push),
    .full       (full),
    .rx_byte_i  (rx_byte_i),
    .empty      (empty),
    .pop        (pop),
    .buttons_o  (buttons_o),
    .delta_x_o  (delta_x_o),
    .delta_y_o  (delta_y_o),
    .cursor_x_o (cursor_x_o),
    .cursor_y_o (cursor_y_o)
  );

  always #4 clk_i = ~clk_i;

  // Centre of an axis, floored at zero
  function automatic int centred(int span, int margin);
    int v;
    v = span - margin;
    if (v < 0) begin
      v = 0;
    end
    return v / 2;
  endfunction

  // Keep a position on screen; a screen narrower than the cursor pins it at 0
  function automatic int clamped(int p, int span);
    int hi;
    hi = span - CURSOR;
    if (hi < 0) begin
      hi = 0;
    end
    if (p < 0) begin
      p = 0;
    end
    if (p > hi) begin
      p = hi;
    end
    return p;
  endfunction

  // Advance the framer by one accepted byte and queue any report it completes
  task automatic track_byte(input logic [7:0] b);
    int             dx;
    int             dy;
    cursor_report_t r;
    case (frame_ph)
      ps2m_pkg::PH_ACK: begin
        if (b == ps2m_pkg::ACK_BYTE) begin
          frame_ph = ps2m_pkg::PH_FIRST;
        end
      end
      ps2m_pkg::PH_FIRST: begin
        if ((b & ps2m_pkg::SYNC_MASK) == ps2m_pkg::SYNC_VALUE) begin
          head_byte = b;
          frame_ph  = ps2m_pkg::PH_SECOND;
        end
      end
      ps2m_pkg::PH_SECOND: begin
        x_byte   = b;
        frame_ph = ps2m_pkg::PH_THIRD;
      end
      default: begin
        frame_ph  = ps2m_pkg::PH_FIRST;
        dx        = int'(x_byte) - (head_byte[ps2m_pkg::X_SIGN_BIT] ? 256 : 0);
        dy        = -(int'(b) - (head_byte[ps2m_pkg::Y_SIGN_BIT] ? 256 : 0));
        ptr_x     = clamped(ptr_x + dx, scr_w);
        ptr_y     = clamped(ptr_y + dy, scr_h);
        r.buttons = head_byte[2:0];
        r.dx      = dx[8:0];
        r.dy      = dy[9:0];
        r.cx      = ptr_x[11:0];
        r.cy      = ptr_y[11:0];
        pending_reports.push_back(r);
      end
    endcase
  endtask

  // Push one byte; bursts of random length with random gaps between them
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    push      <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (full) begin
      @(posedge clk_i);
    end
    track_byte(b);
    @(negedge clk_i);
  endtask

  task automatic send_packet(input logic [7:0] hdr, input logic [7:0] xb,
                             input logic [7:0] yb);
    send_byte(hdr);
    send_byte(xb);
    send_byte(yb);
  endtask

  // Stop pushing, wait for every owed word, then let the pipeline empty
  task automatic settle_block();
    push <= 1'b0;
    while (pending_reports.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // Register write followed by a read-back, only with the block idle
  task automatic write_reg(input ps2m_pkg::reg_idx_e r, input logic [11:0] v);
    settle_block();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= {20'($urandom), v};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // the write lands here and recentres that axis
    if (r == ps2m_pkg::REG_WIDTH) begin
      scr_w = v;
      ptr_x = centred(scr_w, CURSOR);
    end else begin
      scr_h = v;
      ptr_y = centred(scr_h, ps2m_pkg::TASKBAR_ROWS + CURSOR);
    end
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {20'd0, v}) begin
      errors++;
      $display("%0t ns: read-back of register %s expected %0d, got %0d",
               $time, r.name(), v, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Screen size for a random phase: extremes now and then, mostly small
  function automatic logic [11:0] pick_span(int lo);
    case ($urandom_range(0, 5))
      0:       return 12'(lo);
      1:       return 12'd4095;
      2:       return 12'($urandom_range(lo, 4095));
      default: return 12'($urandom_range(lo, lo + 300));
    endcase
  endfunction

  // Motion byte: full range or a small step whose sign matches the header
  function automatic logic [7:0] motion_byte(logic neg);
    int mag;
    if ($urandom_range(0, 1) == 1) begin
      return 8'($urandom);
    end
    mag = $urandom_range(0, 12);
    return neg ? 8'(256 - mag) : 8'(mag);
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Compare every popped word with the oldest owed report
  always @(posedge clk_i) begin : result_check
    cursor_report_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected word: buttons %0d dx %0d dy %0d x %0d y %0d",
                 $time, buttons_o, delta_x_o, delta_y_o, cursor_x_o, cursor_y_o);
      end else begin
        want = pending_reports.pop_front();
        check_field("buttons", want.buttons, buttons_o);
        check_field("delta_x", int'(want.dx), int'(delta_x_o));
        check_field("delta_y", int'(want.dy), int'(delta_y_o));
        check_field("cursor_x", want.cx, cursor_x_o);
        check_field("cursor_y", want.cy, cursor_y_o);
      end
    end
  end

  // Receiver stalls: free-running, coin-flip, sparse and rotating-mask stretches
  always @(negedge clk_i) begin
    pop_tick++;
    if (pop_tick % 48 == 0) begin
      pop_mode = $urandom_range(0, 3);
      pop_mask = 16'($urandom);
    end
    case (pop_mode)
      0:       pop <= 1'b1;
      1:       pop <= 1'($urandom_range(0, 1));
      2:       pop <= ($urandom_range(0, 5) == 0);
      default: begin
        pop      <= pop_mask[0];
        pop_mask = {pop_mask[0], pop_mask[15:1]};
      end
    endcase
  end

  // Watchdog on cycles with no word moving either way
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Bytes before the acknowledge are dropped, valid-looking headers included
  task automatic test_before_ack();
    send_byte(8'h08);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h38);
    send_byte(8'hF9);
    send_byte(8'hFB);
    send_byte(ps2m_pkg::ACK_BYTE);
  endtask

  // Largest and smallest deltas with both signs clear and both set, and all buttons
  task automatic test_packet_extremes();
    send_packet(8'h08, 8'h00, 8'h00);
    send_packet(8'h3F, 8'h00, 8'h00);
    send_packet(8'h08, 8'hFF, 8'hFF);
    send_packet(8'h3A, 8'hFF, 8'hFF);
  endtask

  // Bad headers are skipped; a second acknowledge is just another byte
  task automatic test_resync();
    send_byte(8'hC8);
    send_byte(8'h48);
    send_byte(8'h80);
    send_byte(8'hF7);
    send_byte(ps2m_pkg::ACK_BYTE);
    send_packet(8'h0C, ps2m_pkg::ACK_BYTE, ps2m_pkg::ACK_BYTE);
  endtask

  // Screen sizes at the ends of their ranges, clamping on both sides
  task automatic test_screen_limits();
    write_reg(ps2m_pkg::REG_WIDTH, 12'd16);
    write_reg(ps2m_pkg::REG_HEIGHT, 12'd44);
    send_packet(8'h08, 8'h7F, 8'h81);
    send_packet(8'h39, 8'h80, 8'h7F);
    write_reg(ps2m_pkg::REG_WIDTH, 12'd4095);
    write_reg(ps2m_pkg::REG_HEIGHT, 12'd4095);
    send_packet(8'h0D, 8'hFF, 8'h01);
    send_packet(8'h2E, 8'h10, 8'h00);
    write_reg(ps2m_pkg::REG_WIDTH, 12'd40);
    write_reg(ps2m_pkg::REG_HEIGHT, 12'd60);
    send_packet(8'h08, 8'hFF, 8'h80);
    send_packet(8'h38, 8'h01, 8'h7F);
    write_reg(ps2m_pkg::REG_WIDTH, ps2m_pkg::RESET_WIDTH);
    write_reg(ps2m_pkg::REG_HEIGHT, ps2m_pkg::RESET_HEIGHT);
  endtask

  // Mostly well-formed packets with random content, some noise and broken packets
  task automatic test_random_traffic();
    int         sent;
    int         ph;
    int         kind;
    logic [7:0] hdr;
    for (ph = 0; ph < PHASES; ph++) begin
      write_reg(ps2m_pkg::REG_WIDTH, pick_span(CURSOR));
      write_reg(ps2m_pkg::REG_HEIGHT, pick_span(ps2m_pkg::TASKBAR_ROWS + CURSOR));
      sent = 0;
      while (sent < ITEMS / PHASES) begin
        kind = $urandom_range(0, 9);
        hdr  = {2'b00, 2'($urandom), 1'b1, 3'($urandom)};
        if (kind < 8) begin
          send_packet(hdr, motion_byte(hdr[ps2m_pkg::X_SIGN_BIT]),
                      motion_byte(hdr[ps2m_pkg::Y_SIGN_BIT]));
          sent += 3;
        end else if (kind == 8) begin
          send_byte(($urandom_range(0, 3) == 0) ? ps2m_pkg::ACK_BYTE : 8'($urandom));
          sent++;
        end else begin
          // header and one motion byte, then the next packet cuts in
          send_byte(hdr);
          send_byte(8'($urandom));
          sent += 2;
        end
      end
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    push       = 1'b0;
    rx_byte_i  = '0;
    errors     = 0;
    burst_left = 0;
    frame_ph   = ps2m_pkg::PH_ACK;
    head_byte  = '0;
    x_byte     = '0;
    scr_w      = ps2m_pkg::RESET_WIDTH;
    scr_h      = ps2m_pkg::RESET_HEIGHT;
    ptr_x      = centred(scr_w, CURSOR);
    ptr_y      = centred(scr_h, ps2m_pkg::TASKBAR_ROWS + CURSOR);
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_before_ack();
    test_packet_extremes();
    test_resync();
    test_screen_limits();
    test_random_traffic();

    settle_block();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
